// File: hdl/u8n1_pkg.sv
// Package for the 8N1 serial transceiver: frame constants and the status
// structs passed from the transmit and receive engines to the top level.
// No dependencies.
package u8n1_pkg;

    localparam int unsigned DATA_BITS  = 8;
    localparam int unsigned SLOT_W     = 4;
    localparam int unsigned TIMER_W    = 16;

    // slot 0 is the start bit, slots 1..8 carry data, slot 9 is the stop bit
    localparam logic [SLOT_W-1:0] SLOT_START = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_FIRST = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_LAST  = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_STOP  = 4'd9;

    localparam logic [TIMER_W-1:0] BIT_PERIOD_RST = 16'd32;

    typedef logic [DATA_BITS-1:0] t_byte;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [TIMER_W-1:0]   t_timer;

    typedef struct packed {
        logic level;
        logic busy;
    } t_tx_res;

    typedef struct packed {
        logic  valid;
        t_byte data;
    } t_rx_res;

endpackage

// File: hdl/u8n1_tx.sv
// Transmit engine of the 8N1 transceiver: frame state and the line level for
// the current tick. Advances once per accepted tick. Depends on u8n1_pkg.
module u8n1_tx
    import u8n1_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_timer  i_bit_period,
    input  logic    i_send_valid,
    input  t_byte   i_send_byte,
    output t_tx_res o_res
);

    logic   r_active, n_active;
    t_byte  r_shift, n_shift;
    t_slot  r_slot, n_slot;
    t_timer r_timer, n_timer;

    logic                 start;
    logic                 active_eff;
    t_byte                shift_eff;
    t_slot                slot_eff;
    t_timer               timer_eff;
    logic [TIMER_W:0]     pos;
    logic [SLOT_W-1:0]    slot_nxt;
    logic [SLOT_W-1:0]    data_sel;

    always_comb begin
        start      = !r_active && i_send_valid;
        active_eff = r_active || start;
        shift_eff  = start ? i_send_byte : r_shift;
        slot_eff   = start ? SLOT_START : r_slot;
        timer_eff  = start ? '0 : r_timer;
        pos        = {1'b0, timer_eff} + {{TIMER_W{1'b0}}, 1'b1};
        slot_nxt   = slot_eff + SLOT_FIRST;
        data_sel   = slot_eff - SLOT_FIRST;

        n_active = active_eff;
        n_shift  = shift_eff;
        n_slot   = slot_eff;
        n_timer  = timer_eff;
        o_res    = '{level: 1'b1, busy: 1'b0};

        if (active_eff) begin
            o_res.busy = 1'b1;
            if (slot_eff == SLOT_START) begin
                o_res.level = 1'b0;
            end else if (slot_eff inside {[SLOT_FIRST:SLOT_LAST]}) begin
                o_res.level = shift_eff[data_sel[2:0]];
            end else begin
                o_res.level = 1'b1;
            end
            // bit slot ends: move to the next one, drop back to idle after stop
            if (pos >= {1'b0, i_bit_period}) begin
                n_timer = '0;
                n_slot  = slot_nxt;
                if (slot_nxt > SLOT_STOP) begin
                    n_active = 1'b0;
                    n_slot   = SLOT_START;
                end
            end else begin
                n_timer = pos[TIMER_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_shift  <= '0;
            r_slot   <= '0;
            r_timer  <= '0;
        end else if (i_step) begin
            r_active <= n_active;
            r_shift  <= n_shift;
            r_slot   <= n_slot;
            r_timer  <= n_timer;
        end
    end

endmodule

// File: hdl/u8n1_rx.sv
// Receive engine of the 8N1 transceiver: start detection, mid-bit sampling
// and the holding register for the last byte. Depends on u8n1_pkg.
module u8n1_rx
    import u8n1_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_timer  i_bit_period,
    input  logic    i_rx_level,
    output t_rx_res o_res
);

    logic   r_active, n_active;
    t_byte  r_shift, n_shift;
    t_byte  r_hold, n_hold;
    t_slot  r_slot, n_slot;
    t_timer r_timer, n_timer;

    logic             start;
    logic             active_eff;
    t_slot            slot_eff;
    t_timer           timer_eff;
    t_timer           half;
    logic [TIMER_W:0] pos;

    always_comb begin
        start      = !r_active && !i_rx_level;
        active_eff = r_active || start;
        slot_eff   = start ? SLOT_START : r_slot;
        timer_eff  = start ? '0 : r_timer;
        half       = i_bit_period >> 1;
        pos        = {1'b0, timer_eff} + {{TIMER_W{1'b0}}, 1'b1};

        n_active = active_eff;
        n_shift  = r_shift;
        n_hold   = r_hold;
        n_slot   = slot_eff;
        n_timer  = timer_eff;
        o_res    = '{valid: 1'b0, data: r_hold};

        if (active_eff) begin
            // sample data bits at mid-slot, LSB arrives first
            if (slot_eff inside {[SLOT_FIRST:SLOT_LAST]} && timer_eff == half) begin
                n_shift = {i_rx_level, r_shift[DATA_BITS-1:1]};
            end
            if (pos >= {1'b0, i_bit_period}) begin
                n_timer = '0;
                if (slot_eff >= SLOT_STOP) begin
                    n_active    = 1'b0;
                    n_slot      = SLOT_START;
                    n_hold      = n_shift;
                    o_res.valid = 1'b1;
                    o_res.data  = n_shift;
                end else begin
                    n_slot = slot_eff + SLOT_FIRST;
                end
            end else begin
                n_timer = pos[TIMER_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_shift  <= '0;
            r_hold   <= '0;
            r_slot   <= '0;
            r_timer  <= '0;
        end else if (i_step) begin
            r_active <= n_active;
            r_shift  <= n_shift;
            r_hold   <= n_hold;
            r_slot   <= n_slot;
            r_timer  <= n_timer;
        end
    end

endmodule

// File: hdl/uart_8n1_transceiver_top.sv
// 8N1 serial transceiver: one request is one line tick. The result register
// is loaded in the cycle after acceptance; throughput is one tick per cycle
// while the result register is not held full by back-pressure. The request is
// taken while the result register is empty or being drained. Synchronous
// active-low reset idles both engines, sets the bit period to 32 and clears
// the receive engine's held byte. Depends on u8n1_pkg, u8n1_tx and u8n1_rx.
module uart_8n1_transceiver_top
    import u8n1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_rx_level,
    input  logic        i_send_valid,
    input  logic [7:0]  i_send_byte,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_tx_level,
    output logic        o_tx_busy,
    output logic        o_rx_valid,
    output logic [7:0]  o_rx_byte
);

    t_timer  r_bit_period;
    logic    r_out_valid;
    logic    r_tx_level;
    logic    r_tx_busy;
    logic    r_rx_valid;
    t_byte   r_rx_byte;

    logic    step;
    t_tx_res tx_res;
    t_rx_res rx_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign step        = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= BIT_PERIOD_RST;
        end else if (i_cfg_valid) begin
            r_bit_period <= i_cfg_data;
        end
    end

    u8n1_tx u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_bit_period (r_bit_period),
        .i_send_valid (i_send_valid),
        .i_send_byte  (i_send_byte),
        .o_res        (tx_res)
    );

    u8n1_rx u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_bit_period (r_bit_period),
        .i_rx_level   (i_rx_level),
        .o_res        (rx_res)
    );

    // hold the result until taken; refill on every accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_tx_level <= tx_res.level;
            r_tx_busy  <= tx_res.busy;
            r_rx_valid <= rx_res.valid;
            r_rx_byte  <= rx_res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_level  = r_tx_level;
    assign o_tx_busy   = r_tx_busy;
    assign o_rx_valid  = r_rx_valid;
    assign o_rx_byte   = r_rx_byte;

endmodule
